/* rtl/sqlsb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sqlsb_pkg;

    localparam int unsigned OFS_W = 25;
    localparam logic [OFS_W-1:0] MAX_TEXT = 25'd16777216;

    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_DOLLAR = 16'h0024;
    localparam logic [15:0] CH_DASH   = 16'h002D;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_QUOTE  = 16'h0027;
    localparam logic [15:0] CH_LF     = 16'h000A;

    // lexical mode codes
    localparam logic [2:0] M_NORMAL = 3'd0;
    localparam logic [2:0] M_LINE   = 3'd1;
    localparam logic [2:0] M_BLOCK  = 3'd2;
    localparam logic [2:0] M_SQUOTE = 3'd3;
    localparam logic [2:0] M_DOLLAR = 3'd4;

    typedef struct packed {
        logic [OFS_W-1:0] seg_start;
        logic [OFS_W-1:0] seg_end;
        logic [OFS_W-1:0] text_start;
        logic [OFS_W-1:0] text_end;
        logic             seg_empty;
        logic             final_segment;
        logic             tag_overflow;
    } t_result;

    function automatic logic is_word(input logic [15:0] c);
        is_word = (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A) ||
                  (c >= 16'h0030 && c <= 16'h0039) || (c == 16'h005F);
    endfunction

    function automatic logic is_space(input logic [15:0] c);
        is_space = (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
    endfunction

endpackage
`default_nettype wire

/* rtl/sqlsb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface sqlsb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] ch;
    logic        last_char;
    modport source (output valid, ch, last_char, input ready);
    modport sink (input valid, ch, last_char, output ready);
endinterface

interface sqlsb_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] seg_start;
    logic [24:0] seg_end;
    logic [24:0] text_start;
    logic [24:0] text_end;
    logic        seg_empty;
    logic        final_segment;
    logic        tag_overflow;
    modport source (output valid, seg_start, seg_end, text_start, text_end, seg_empty,
                    final_segment, tag_overflow, input ready);
    modport sink (input valid, seg_start, seg_end, text_start, text_end, seg_empty,
                  final_segment, tag_overflow, output ready);
endinterface
`default_nettype wire

/* rtl/sqlsb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sqlsb_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/sql_statement_boundary_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none
// sql statement boundary scanner: takes one utf-16 code unit per cycle and splits the text
// into segments at semicolons outside comments, quoted strings and dollar-quoted bodies.
// every character is taken back to back; the tag compare reads the open tag from a banked
// ram whose address is issued in the cycle before from the next candidate length, so there
// is no stall for it. a character yields up to two segment transactions (one for
// a semicolon, one final at last_char); they queue in a four-entry output fifo and input
// ready drops only while fewer than two fifo slots are free. open tag and candidate share
// one ram in two banks; opening a dollar quote swaps the bank roles instead of copying.
// no clearing pass is needed after reset. offsets saturate at 2**24.
module sql_statement_boundary_scanner
    import sqlsb_pkg::*;
#(
    parameter int unsigned MAX_TAG = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sqlsb_in_if.sink    i_in,
    sqlsb_out_if.source o_out
);
    localparam int unsigned LW = $clog2(MAX_TAG + 1);
    localparam int unsigned IW = (MAX_TAG > 1) ? $clog2(MAX_TAG) : 1;
    localparam int unsigned AW = IW + 1;
    localparam logic [LW-1:0] TAG_MAX = LW'(MAX_TAG);
    localparam int unsigned FD = 4;

    // lexer state
    logic [2:0]       r_mode, n_mode;
    logic [15:0]      r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [LW-1:0]    r_otl, n_otl;
    logic [LW-1:0]    r_len, n_len;
    logic             r_active, n_active;
    logic             r_match, n_match;
    logic             r_bank, n_bank;
    logic [OFS_W-1:0] r_pos, n_pos;
    logic [OFS_W-1:0] r_sos, n_sos;
    logic [OFS_W-1:0] r_fns, n_fns;
    logic [OFS_W-1:0] r_lne, n_lne;
    logic             r_seen, n_seen;
    logic             r_ovf, n_ovf;

    // output fifo
    t_result    r_fifo [FD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;

    logic        acc, semi, push_fin;
    logic        wr_en;
    logic [15:0] rd_data;
    t_result     res_a, res_b;

    assign acc = i_in.valid && i_in.ready;

    // open tag bank is r_bank, candidate chars go to the other bank
    sqlsb_ram #(.WIDTH(16), .DEPTH(2 ** AW)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr ({~r_bank, r_len[IW-1:0]}),
        .i_wdata (i_in.ch),
        .i_raddr ({n_bank, n_len[IW-1:0]}),
        .o_rdata (rd_data)
    );

    always_comb begin
        logic [15:0]      c;
        logic [2:0]       m;
        logic             skip, handled, needs;
        logic [OFS_W-1:0] pos_new, fns1, lne1;
        logic             seen1, ovf1, seen2, ovf2;
        logic [OFS_W-1:0] sos2;

        c = i_in.ch;
        n_mode = r_mode; n_held = r_held; n_held_valid = r_held_valid;
        n_otl = r_otl; n_len = r_len; n_active = r_active; n_match = r_match;
        n_bank = r_bank; n_pos = r_pos; n_sos = r_sos; n_fns = r_fns; n_lne = r_lne;
        n_seen = r_seen; n_ovf = r_ovf;
        wr_en = 1'b0; semi = 1'b0; push_fin = 1'b0;
        m = r_mode; skip = 1'b0; handled = 1'b0; needs = 1'b0;
        pos_new = (r_pos < MAX_TEXT) ? r_pos + 1'b1 : r_pos;
        fns1 = r_fns; lne1 = r_lne; seen1 = r_seen; ovf1 = r_ovf;
        seen2 = r_seen; ovf2 = r_ovf; sos2 = r_sos;
        res_a = '0; res_b = '0;

        if (acc) begin
            n_pos = pos_new;
            if (!is_space(c)) begin
                if (!r_seen) fns1 = r_pos;
                lne1 = pos_new;
                seen1 = 1'b1;
            end

            // resolve the held character now that its successor is known
            if (r_held_valid) begin
                n_held_valid = 1'b0;
                case (r_mode)
                    M_NORMAL: begin
                        if (r_held == CH_DASH && c == CH_DASH) m = M_LINE;
                        else if (r_held == CH_SLASH && c == CH_STAR) m = M_BLOCK;
                    end
                    M_BLOCK: begin
                        if (r_held == CH_STAR && c == CH_SLASH) begin
                            skip = 1'b1;
                            m = M_NORMAL;
                        end
                    end
                    M_SQUOTE: begin
                        if (r_held == CH_QUOTE) begin
                            if (c == CH_QUOTE) skip = 1'b1;
                            else m = M_NORMAL;
                        end
                    end
                    default: ;
                endcase
            end

            if (!skip) begin
                // dollar tag candidate
                if (r_active) begin
                    if (is_word(c)) begin
                        handled = 1'b1;
                        if (r_len >= TAG_MAX) begin
                            ovf1 = 1'b1;
                            n_active = 1'b0;
                        end else begin
                            wr_en = 1'b1;
                            if (!(r_len < r_otl && rd_data == c)) n_match = 1'b0;
                            n_len = r_len + 1'b1;
                        end
                    end else begin
                        n_active = 1'b0;
                        if (c == CH_DOLLAR) begin
                            if (m == M_DOLLAR) begin
                                if (r_match && r_len == r_otl) begin
                                    m = M_NORMAL;
                                    n_otl = '0;
                                    handled = 1'b1;
                                end
                            end else if (m == M_NORMAL) begin
                                n_otl = r_len;
                                n_bank = ~r_bank;
                                m = M_DOLLAR;
                                handled = 1'b1;
                            end
                        end
                    end
                end

                if (!handled) begin
                    needs = (m == M_NORMAL && (c == CH_DASH || c == CH_SLASH)) ||
                            (m == M_BLOCK && c == CH_STAR) ||
                            (m == M_SQUOTE && c == CH_QUOTE);
                    if (!i_in.last_char && needs) begin
                        n_held = c;
                        n_held_valid = 1'b1;
                    end else begin
                        case (m)
                            M_LINE:   if (c == CH_LF) m = M_NORMAL;
                            M_BLOCK:  ;
                            M_SQUOTE: if (c == CH_QUOTE) m = M_NORMAL;
                            M_DOLLAR: begin
                                if (c == CH_DOLLAR) begin
                                    n_active = 1'b1; n_len = '0; n_match = 1'b1;
                                end
                            end
                            default: begin
                                m = M_NORMAL;
                                if (c == CH_DOLLAR) begin
                                    n_active = 1'b1; n_len = '0; n_match = 1'b1;
                                end else if (c == CH_QUOTE) begin
                                    m = M_SQUOTE;
                                end else if (c == CH_SEMI) begin
                                    semi = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            n_mode = m;

            // segment closed by a semicolon
            res_a.seg_start     = r_sos;
            res_a.seg_end       = pos_new;
            res_a.text_start    = seen1 ? fns1 : r_sos;
            res_a.text_end      = seen1 ? lne1 : r_sos;
            res_a.seg_empty     = ~seen1;
            res_a.final_segment = 1'b0;
            res_a.tag_overflow  = ovf1;
            if (semi) begin
                sos2 = pos_new; seen2 = 1'b0; ovf2 = 1'b0;
            end else begin
                seen2 = seen1; ovf2 = ovf1;
            end
            // trailing segment at end of text
            res_b.seg_start     = sos2;
            res_b.seg_end       = pos_new;
            res_b.text_start    = seen2 ? fns1 : sos2;
            res_b.text_end      = seen2 ? lne1 : sos2;
            res_b.seg_empty     = ~seen2;
            res_b.final_segment = 1'b1;
            res_b.tag_overflow  = ovf2;

            n_sos = sos2; n_seen = seen2; n_ovf = ovf2; n_fns = fns1; n_lne = lne1;

            if (i_in.last_char) begin
                push_fin = 1'b1;
                n_mode = M_NORMAL; n_held = '0; n_held_valid = 1'b0;
                n_otl = '0; n_len = '0; n_active = 1'b0; n_match = 1'b1;
                n_pos = '0; n_sos = '0; n_fns = '0; n_lne = '0;
                n_seen = 1'b0; n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL; r_held <= '0; r_held_valid <= 1'b0;
            r_otl <= '0; r_len <= '0; r_active <= 1'b0; r_match <= 1'b1;
            r_bank <= 1'b0; r_pos <= '0; r_sos <= '0; r_fns <= '0; r_lne <= '0;
            r_seen <= 1'b0; r_ovf <= 1'b0;
        end else begin
            r_mode <= n_mode; r_held <= n_held; r_held_valid <= n_held_valid;
            r_otl <= n_otl; r_len <= n_len; r_active <= n_active; r_match <= n_match;
            r_bank <= n_bank; r_pos <= n_pos; r_sos <= n_sos; r_fns <= n_fns;
            r_lne <= n_lne; r_seen <= n_seen; r_ovf <= n_ovf;
        end
    end

    // output fifo: up to two pushes and one pop per cycle
    logic       pop;
    logic [1:0] n_push;
    assign pop    = o_out.valid && o_out.ready;
    assign n_push = {1'b0, semi} + {1'b0, push_fin};

    always_ff @(posedge i_clk) begin
        if (semi) begin
            r_fifo[r_wp] <= res_a;
        end else if (push_fin) begin
            r_fifo[r_wp] <= res_b;
        end
        if (semi && push_fin) begin
            r_fifo[r_wp + 2'd1] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            r_wp <= r_wp + n_push;
            if (pop) r_rp <= r_rp + 2'd1;
            r_count <= r_count + {1'b0, n_push} - {2'b0, pop};
        end
    end

    assign i_in.ready          = (r_count <= 3'(FD - 2));
    assign o_out.valid         = (r_count != 3'd0);
    assign o_out.seg_start     = r_fifo[r_rp].seg_start;
    assign o_out.seg_end       = r_fifo[r_rp].seg_end;
    assign o_out.text_start    = r_fifo[r_rp].text_start;
    assign o_out.text_end      = r_fifo[r_rp].text_end;
    assign o_out.seg_empty     = r_fifo[r_rp].seg_empty;
    assign o_out.final_segment = r_fifo[r_rp].final_segment;
    assign o_out.tag_overflow  = r_fifo[r_rp].tag_overflow;

    // fifo never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(FD)) else $error("output fifo overflow");

    // candidate and open tag lengths stay within the tag store
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len <= TAG_MAX) && (r_otl <= TAG_MAX)) else $error("tag length out of range");

    // end of text returns the scanner to its start state
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.last_char) |=> (r_pos == '0 && r_mode == M_NORMAL && !r_held_valid))
        else $error("scanner not reset after last character");

    // a held character only ever waits in a mode that holds lookahead
    a_held_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_mode == M_NORMAL || r_mode == M_BLOCK || r_mode == M_SQUOTE))
        else $error("held character in wrong mode");
endmodule
`default_nettype wire

/* bench/tb_sql_statement_boundary_scanner.sv */
`timescale 1ns / 1ps
module tb_sql_statement_boundary_scanner;
    import sqlsb_pkg::*;

    localparam int TAG_MAX = 32;
    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    sqlsb_in_if  in_ch();
    sqlsb_out_if out_ch();

    sql_statement_boundary_scanner #(.MAX_TAG(TAG_MAX)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // scanner state kept by the bench
    logic [2:0]       sc_mode;
    logic [15:0]      sc_held;
    logic             sc_held_v;
    logic             sc_skip;
    logic [15:0]      sc_open_tag [TAG_MAX];
    int               sc_open_len;
    logic [15:0]      sc_cand [TAG_MAX];
    int               sc_cand_len;
    logic             sc_cand_on;
    logic             sc_cand_eq;
    logic [OFS_W-1:0] sc_pos;
    logic [OFS_W-1:0] sc_seg_start;
    logic [OFS_W-1:0] sc_first_ns;
    logic [OFS_W-1:0] sc_last_ns_end;
    logic             sc_seen_ns;
    logic             sc_ovf;

    t_result pending_segments[$];
    int      mismatches;
    int      chars_sent;
    int      segs_checked;
    int      idle_cycles;
    logic    done;

    function automatic logic word_ch(logic [15:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic blank_ch(logic [15:0] c);
        return c == 16'h20 || (c >= 16'h09 && c <= 16'h0D);
    endfunction

    task automatic scanner_clear();
        sc_mode = M_NORMAL;
        sc_held = '0;
        sc_held_v = 0;
        sc_skip = 0;
        sc_open_len = 0;
        sc_cand_len = 0;
        sc_cand_on = 0;
        sc_cand_eq = 1;
        sc_pos = '0;
        sc_seg_start = '0;
        sc_first_ns = '0;
        sc_last_ns_end = '0;
        sc_seen_ns = 0;
        sc_ovf = 0;
    endtask

    task automatic close_segment(logic [OFS_W-1:0] seg_end, logic fin);
        t_result r;
        r.seg_start = sc_seg_start;
        r.seg_end = seg_end;
        r.text_start = sc_seen_ns ? sc_first_ns : sc_seg_start;
        r.text_end = sc_seen_ns ? sc_last_ns_end : sc_seg_start;
        r.seg_empty = !sc_seen_ns;
        r.final_segment = fin;
        r.tag_overflow = sc_ovf;
        pending_segments = {pending_segments, r};
        sc_seg_start = seg_end;
        sc_seen_ns = 0;
        sc_ovf = 0;
    endtask

    task automatic open_candidate();
        sc_cand_on = 1;
        sc_cand_len = 0;
        sc_cand_eq = 1;
    endtask

    // dollar tag candidate; returns 1 when the character is consumed
    function automatic logic tag_candidate(logic [15:0] c);
        if (!sc_cand_on) return 0;
        if (word_ch(c)) begin
            if (sc_cand_len >= TAG_MAX) begin
                sc_ovf = 1;
                sc_cand_on = 0;
            end else begin
                sc_cand[sc_cand_len] = c;
                if (sc_cand_len >= sc_open_len || sc_open_tag[sc_cand_len] != c)
                    sc_cand_eq = 0;
                sc_cand_len++;
            end
            return 1;
        end
        sc_cand_on = 0;
        if (c != CH_DOLLAR) return 0;
        if (sc_mode == M_DOLLAR) begin
            if (sc_cand_eq && sc_cand_len == sc_open_len) begin
                sc_mode = M_NORMAL;
                sc_open_len = 0;
                return 1;
            end
            return 0;
        end
        if (sc_mode == M_NORMAL) begin
            for (int i = 0; i < sc_cand_len; i++) sc_open_tag[i] = sc_cand[i];
            sc_open_len = sc_cand_len;
            sc_mode = M_DOLLAR;
            return 1;
        end
        return 0;
    endfunction

    function automatic logic must_hold(logic [15:0] c);
        case (sc_mode)
            M_NORMAL: return c == CH_DASH || c == CH_SLASH;
            M_BLOCK:  return c == CH_STAR;
            M_SQUOTE: return c == CH_QUOTE;
            default:  return 0;
        endcase
    endfunction

    task automatic lex_char(logic [15:0] c, logic has_nx, logic [15:0] nx);
        case (sc_mode)
            M_LINE: if (c == CH_LF) sc_mode = M_NORMAL;
            M_BLOCK: begin
                if (c == CH_STAR && has_nx && nx == CH_SLASH) begin
                    sc_skip = 1;
                    sc_mode = M_NORMAL;
                end
            end
            M_SQUOTE: begin
                if (c == CH_QUOTE) begin
                    if (has_nx && nx == CH_QUOTE) sc_skip = 1;
                    else sc_mode = M_NORMAL;
                end
            end
            M_DOLLAR: if (c == CH_DOLLAR) open_candidate();
            default: begin
                sc_mode = M_NORMAL;
                if (c == CH_DASH && has_nx && nx == CH_DASH) sc_mode = M_LINE;
                else if (c == CH_SLASH && has_nx && nx == CH_STAR) sc_mode = M_BLOCK;
                else if (c == CH_DOLLAR) open_candidate();
                else if (c == CH_QUOTE) sc_mode = M_SQUOTE;
                else if (c == CH_SEMI) close_segment(sc_pos, 1'b0);
            end
        endcase
    endtask

    // expected segments for one accepted character
    task automatic predict_segments(logic [15:0] c, logic last);
        logic [OFS_W-1:0] idx;
        idx = sc_pos;
        if (sc_pos < MAX_TEXT) sc_pos++;
        if (!blank_ch(c)) begin
            if (!sc_seen_ns) sc_first_ns = idx;
            sc_last_ns_end = sc_pos;
            sc_seen_ns = 1;
        end
        if (sc_held_v) begin
            sc_held_v = 0;
            lex_char(sc_held, 1'b1, c);
        end
        if (sc_skip) begin
            sc_skip = 0;
        end else if (!tag_candidate(c)) begin
            if (!last && must_hold(c)) begin
                sc_held = c;
                sc_held_v = 1;
            end else begin
                lex_char(c, 1'b0, 16'h0000);
            end
        end
        if (last) begin
            close_segment(sc_pos, 1'b1);
            scanner_clear();
        end
    endtask

    // called at a falling edge; valid stays high across a back-to-back transaction
    task automatic send_char(logic [15:0] c, logic last);
        int w;
        w = $urandom_range(0, 7);
        if (w != 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch <= c;
        in_ch.last_char <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_segments(c, last);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, logic close_text);
        for (int i = 0; i < s.len(); i++)
            send_char(16'(s[i]), close_text && i == s.len() - 1);
    endtask

    // segment checker: compares every output transaction to the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.seg_start = out_ch.seg_start;
            got.seg_end = out_ch.seg_end;
            got.text_start = out_ch.text_start;
            got.text_end = out_ch.text_end;
            got.seg_empty = out_ch.seg_empty;
            got.final_segment = out_ch.final_segment;
            got.tag_overflow = out_ch.tag_overflow;
            if (pending_segments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected segment %p", got);
            end else begin
                exp_r = pending_segments.pop_front();
                segs_checked++;
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("segment mismatch: expected %p got %p", exp_r, got);
                end
            end
        end
    end

    // sink stalls drawn per transaction
    initial begin
        int w;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            w = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) w = 0;
            repeat (w) begin
                out_ch.ready <= 1'b0;
                @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed_statements();
        send_text("SELECT 1; ", 1);
        send_text("  ;a--x;\n;b/*;*/;", 1);
        send_text("'it''s;';$$;$$;$q$ $x$ ; $q$;", 1);
        send_char(16'hFFFF, 0);
        send_char(16'h0000, 0);
        send_char(16'h000B, 0);
        send_char(CH_SEMI, 1);
    endtask

    task automatic test_last_char_edges();
        send_char(CH_DASH, 1);
        send_char(CH_SEMI, 1);
        send_char(16'(" "), 1);
        send_text("/", 0);
        send_text("*x*", 1);
    endtask

    task automatic test_tag_overflow();
        send_char(CH_DOLLAR, 0);
        repeat (TAG_MAX + 1) send_char(16'("t"), 0);
        send_text("$;", 1);
    endtask

    function automatic logic [15:0] pick_char();
        case ($urandom_range(0, 17))
            0, 1:    return CH_SEMI;
            2:       return CH_DOLLAR;
            3:       return CH_DASH;
            4:       return CH_SLASH;
            5:       return CH_STAR;
            6:       return CH_QUOTE;
            7:       return CH_LF;
            8, 9:    return 16'(" ");
            10:      return 16'($urandom_range(9, 13));
            11:      return 16'($urandom);
            12:      return 16'("_");
            13:      return 16'("t");
            default: return 16'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic test_random_texts();
        string frag;
        int len;
        while (chars_sent < 810) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                // well-formed constructs mixed with random characters
                case ($urandom_range(0, 9))
                    0: send_text("$t$ a;b $t$", 0);
                    1: send_text("'x;''y'", 0);
                    2: send_text("/* ; */", 0);
                    3: send_text("-- ;\n", 0);
                    default: send_char(pick_char(), 0);
                endcase
            end
            send_char(pick_char(), 1);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.ch = '0;
        in_ch.last_char = 1'b0;
        i_rst_n = 1'b0;
        mismatches = 0;
        chars_sent = 0;
        segs_checked = 0;
        idle_cycles = 0;
        done = 0;
        for (int i = 0; i < TAG_MAX; i++) begin
            sc_open_tag[i] = '0;
            sc_cand[i] = '0;
        end
        scanner_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_statements();
        test_last_char_edges();
        test_tag_overflow();
        test_random_texts();
        in_ch.valid <= 1'b0;

        while (pending_segments.size() != 0) @(posedge i_clk);
        done = 1;
        repeat (20) @(posedge i_clk);
        $display("sent %0d characters, checked %0d segments", chars_sent, segs_checked);
        if (mismatches == 0 && pending_segments.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
